/* rtl/trwl_pkg.sv */
// shared types and constants for the thread ready and wait lists block
// no dependencies
`default_nettype none
package trwl_pkg;
  // list sizes, fixed by the 6-bit thread and 3-bit priority fields
  localparam int NUM_THREADS    = 64;
  localparam int NUM_PRIORITIES = 8;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_APPEND = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_LISTED  = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture the input beat
    logic rd_links;   // read links of the operand threads
    logic apply;      // write the link rams
    logic out_load;   // load the result register and update list state
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

/* rtl/trwl_if.sv */
// valid/ready channel carrying one command beat or one result beat
// depends on nothing
`default_nettype none
interface trwl_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] thread_id;
  logic [2:0] priority_req;
  modport source (output valid, command, thread_id, priority_req, input ready);
  modport sink (input valid, command, thread_id, priority_req, output ready);
endinterface

interface trwl_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] popped_thread;
  logic [1:0] status;
  logic [6:0] count_after;
  modport source (output valid, popped_thread, status, count_after, input ready);
  modport sink (input valid, popped_thread, status, count_after, output ready);
endinterface
`default_nettype wire

/* rtl/trwl_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module trwl_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/trwl_ctrl.sv */
// sequencer: idle, read links, apply, present result
// uses trwl_pkg
`default_nettype none
module trwl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire trwl_pkg::sts_t  sts,
  output      trwl_pkg::ctl_t  ctl
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state, state_next;

  always_comb begin
    state_next   = state;
    ctl          = '0;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        ctl.rd_links = 1'b1;
        state_next   = S_APPLY;
      end
      S_APPLY: state_next = S_OUT;
      S_OUT: begin
        if (!sts.out_full) begin
          ctl.apply    = 1'b1;
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_read_after_latch: assert property (@(posedge clk) disable iff (rst)
    ctl.latch |=> ctl.rd_links) else $error("no link read after accept");
  a_single_load: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |=> !ctl.out_load) else $error("double result load");
`endif
endmodule
`default_nettype wire

/* rtl/trwl_dp.sv */
// list datapath: link rams, head/tail/count registers, membership bits, result register
// uses trwl_pkg and trwl_ram
`default_nettype none
module trwl_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire trwl_pkg::ctl_t ctl,
  output      trwl_pkg::sts_t sts,
  input  wire logic [1:0]     command,
  input  wire logic [5:0]     thread_id,
  input  wire logic [2:0]     priority_req,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      logic [5:0]     popped_thread,
  output      logic [1:0]     status,
  output      logic [6:0]     count_after
);
  localparam int NUM_THREADS    = trwl_pkg::NUM_THREADS;
  localparam int NUM_PRIORITIES = trwl_pkg::NUM_PRIORITIES;
  localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int CW = $clog2(NUM_THREADS + 1);

  logic [1:0]    cmd;
  logic [TW-1:0] t;
  logic [PW-1:0] p;
  logic [TW-1:0] ready_head [NUM_PRIORITIES];
  logic [TW-1:0] ready_tail [NUM_PRIORITIES];
  logic [CW-1:0] ready_count [NUM_PRIORITIES];
  logic [TW-1:0] wait_head, wait_tail;
  logic [CW-1:0] wait_count;
  logic [NUM_THREADS-1:0] is_queued, is_waiting;

  // input capture with modulo wrap of thread and priority
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd <= command;
      t   <= TW'(32'(thread_id) % NUM_THREADS);
      p   <= PW'(32'(priority_req) % NUM_PRIORITIES);
    end
  end

  // links: next read at head (pop) or target thread, prev read at target
  logic          nx_we, pv_we;
  logic [TW-1:0] nx_wa, pv_wa, nx_wd, pv_wd, nx_ra, nx_rd, pv_rd;

  trwl_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  trwl_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(t), .rdata(pv_rd));

  assign nx_ra = (cmd == trwl_pkg::CMD_POP) ? ready_head[p] : t;

  logic [CW-1:0] rc, wc;
  logic          listed;
  assign rc     = ready_count[p];
  assign wc     = wait_count;
  assign listed = is_queued[t] | is_waiting[t];

  // second link write for middle removal is done as a prev write alongside
  always_comb begin
    nx_we = 1'b0; pv_we = 1'b0;
    nx_wa = t; nx_wd = t; pv_wa = t; pv_wd = t;
    if (ctl.apply) begin
      case (cmd)
        trwl_pkg::CMD_PUSH: if (!listed && rc != '0) begin
          nx_we = 1'b1; nx_wa = ready_tail[p]; nx_wd = t;
          pv_we = 1'b1; pv_wa = t; pv_wd = ready_tail[p];
        end
        trwl_pkg::CMD_APPEND: if (!listed && wc != '0) begin
          nx_we = 1'b1; nx_wa = wait_tail; nx_wd = t;
          pv_we = 1'b1; pv_wa = t; pv_wd = wait_tail;
        end
        trwl_pkg::CMD_REMOVE: if (is_waiting[t] && wc > CW'(1)
                                  && t != wait_head && t != wait_tail) begin
          nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
          pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
        end
        default: ;
      endcase
    end
  end

  assign sts.out_full = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        ready_head[i] <= '0; ready_tail[i] <= '0; ready_count[i] <= '0;
      end
      wait_head <= '0; wait_tail <= '0; wait_count <= '0;
      is_queued <= '0; is_waiting <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctl.out_load) begin
        out_valid     <= 1'b1;
        popped_thread <= '0;
        status        <= trwl_pkg::ST_OK;
        case (cmd)
          trwl_pkg::CMD_PUSH: begin
            if (listed) begin
              status <= trwl_pkg::ST_LISTED; count_after <= 7'(rc);
            end else begin
              if (rc == '0) ready_head[p] <= t;
              ready_tail[p]  <= t;
              ready_count[p] <= rc + 1'b1;
              is_queued[t]   <= 1'b1;
              count_after    <= 7'(rc + 1'b1);
            end
          end
          trwl_pkg::CMD_POP: begin
            if (rc == '0) begin
              status <= trwl_pkg::ST_EMPTY; count_after <= '0;
            end else begin
              if (rc == CW'(1)) begin
                ready_head[p] <= '0; ready_tail[p] <= '0;
              end else ready_head[p] <= nx_rd;
              ready_count[p]           <= rc - 1'b1;
              is_queued[ready_head[p]] <= 1'b0;
              popped_thread            <= 6'(ready_head[p]);
              count_after              <= 7'(rc - 1'b1);
            end
          end
          trwl_pkg::CMD_APPEND: begin
            if (listed) begin
              status <= trwl_pkg::ST_LISTED; count_after <= 7'(wc);
            end else begin
              if (wc == '0) wait_head <= t;
              wait_tail     <= t;
              wait_count    <= wc + 1'b1;
              is_waiting[t] <= 1'b1;
              count_after   <= 7'(wc + 1'b1);
            end
          end
          default: begin
            if (!is_waiting[t]) begin
              status <= trwl_pkg::ST_ABSENT; count_after <= 7'(wc);
            end else begin
              if (wc <= CW'(1)) begin
                wait_head <= '0; wait_tail <= '0;
              end else if (t == wait_head) wait_head <= nx_rd;
              else if (t == wait_tail) wait_tail <= pv_rd;
              wait_count    <= (wc != '0) ? wc - 1'b1 : wc;
              is_waiting[t] <= 1'b0;
              count_after   <= 7'((wc != '0) ? wc - 1'b1 : wc);
            end
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    (is_queued & is_waiting) == '0) else $error("thread in two lists");
  a_wait_count: assert property (@(posedge clk) disable iff (rst)
    32'(wait_count) == $countones(is_waiting)) else $error("wait count mismatch");
  a_pop_thread: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load && cmd != trwl_pkg::CMD_POP |=> popped_thread == '0)
    else $error("nonzero popped thread");
`endif
endmodule
`default_nettype wire

/* rtl/thread_ready_and_wait_lists_top.sv */
// top level of the thread ready and wait lists block
// uses trwl_pkg, trwl_if, trwl_ctrl, trwl_dp, trwl_ram
//
// usage:
// - cmd channel (sink): one beat carries command, thread_id and priority_req
//   commands: ready push, ready pop, waiting append, waiting remove
// - res channel (source): exactly one result beat per command beat,
//   with popped_thread, status and count_after
// - the block works on one command at a time: it takes a beat in idle,
//   reads the link rams of the operand threads (one registered read per
//   ram), then applies the update and loads the result register
// - after the command beat is taken, the block passes the read, apply and
//   output steps; the result beat goes valid once the result register loads
// - a new command beat is taken only after the last result is loaded; this
//   is set by the registered link ram read and the single shared update step
// - receiver stall: the result register holds its beat; a pending command
//   waits in its last step until the register frees, cmd ready stays low
// - reset (synchronous, active high): all lists empty, membership bits
//   clear; the link rams need no clearing since only listed threads are read
`default_nettype none
module thread_ready_and_wait_lists_top (
  input wire logic clk,
  input wire logic rst,
  trwl_cmd_if.sink   cmd,
  trwl_res_if.source res
);
  trwl_pkg::ctl_t ctl;
  trwl_pkg::sts_t sts;

  // sequencer
  trwl_ctrl u_ctrl (
    .clk, .rst, .in_valid(cmd.valid), .in_ready(cmd.ready), .sts, .ctl);

  // list storage and result register
  trwl_dp u_dp (
    .clk, .rst, .ctl, .sts,
    .command(cmd.command), .thread_id(cmd.thread_id),
    .priority_req(cmd.priority_req),
    .out_valid(res.valid), .out_ready(res.ready),
    .popped_thread(res.popped_thread), .status(res.status),
    .count_after(res.count_after));

`ifndef SYNTHESIS
  a_res_after_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |-> ##4 res.valid) else $error("missing result");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> !cmd.ready) else $error("overlapping commands");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.status))
    else $error("result dropped under stall");
`endif
endmodule
`default_nettype wire
